// ----- hw/rtl/tbw_pkg.sv -----
// Shared constants, types and helpers for the triangle barycentric weight pipeline.
`default_nettype none
package tbw_pkg;
  localparam int FRACTION_BITS = 16;
  localparam int COORD_BITS    = 12;
  localparam int W    = 24;
  localparam int DW   = COORD_BITS + 1;
  localparam int PW   = 2 * DW;
  localparam int EW   = PW + 1;
  localparam int NB   = EW + FRACTION_BITS;
  localparam int IN_TW  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_TW = ((3 * W + 7) / 8) * 8;
  localparam int IDX_W  = 3;

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [IDX_W-1:0] {
    REG_V0X = 3'd0,
    REG_V0Y = 3'd1,
    REG_V1X = 3'd2,
    REG_V1Y = 3'd3,
    REG_V2X = 3'd4,
    REG_V2Y = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [EW-1:0] rem;
    logic [W-1:0]  nlow;
    logic [W-1:0]  q;
    logic          neg;
    logic          ovf;
  } lane_t;

  typedef struct packed {
    lane_t la;
    lane_t lb;
    logic  deg;
  } stg_t;

  function automatic logic signed [DW-1:0] csub(logic signed [COORD_BITS-1:0] a,
                                                logic signed [COORD_BITS-1:0] b);
    return $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/tbw_cell.sv -----
// One divider cell: produces one quotient bit per lane and passes the item on.
`default_nettype none
module tbw_cell import tbw_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  input  stg_t          up_data,
  output logic          up_move,
  input  logic [EW-1:0] dmag,
  output logic          dn_valid,
  output stg_t          dn_data,
  input  logic          dn_move
);
  logic valid_r;
  stg_t data_r;
  stg_t data_nxt;

  function automatic lane_t step(lane_t l, logic [EW-1:0] d);
    logic [EW:0] t;
    logic        ge;
    lane_t       r;
    t = {l.rem, l.nlow[W-1]};
    ge = t >= {1'b0, d};
    r = l;
    r.rem = ge ? EW'(t - {1'b0, d}) : EW'(t);
    r.nlow = {l.nlow[W-2:0], 1'b0};
    r.q = {l.q[W-2:0], ge};
    return r;
  endfunction

  assign up_move = !valid_r || dn_move;

  always_comb begin
    data_nxt = up_data;
    data_nxt.la = step(up_data.la, dmag);
    data_nxt.lb = step(up_data.lb, dmag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_move) begin
      valid_r <= up_valid;
    end
    if (up_move) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data = data_r;
endmodule
`default_nettype wire

// ----- hw/rtl/tbw_post.sv -----
// Sign, saturation, third weight and output register of the weight pipeline.
`default_nettype none
module tbw_post import tbw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  input  stg_t              up_data,
  output logic              up_move,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_TW-1:0] out_tdata,
  output logic              out_tuser
);
  localparam logic signed [W+2:0] ONE_X = (W+3)'(1) <<< FRACTION_BITS;

  logic                vw_r;
  logic signed [W-1:0] w2_r, w0_r;
  logic                degw_r;
  logic                ov_r;
  logic signed [W-1:0] o1_r, o2_r, o0_r;
  logic                odeg_r;
  logic                o_move;
  logic signed [W+2:0] t1;
  logic signed [W-1:0] w1_nxt;

  function automatic logic signed [W-1:0] sat_lane(lane_t l);
    logic signed [W+1:0] s;
    logic signed [W-1:0] r;
    s = l.neg ? -$signed({2'b00, l.q}) : $signed({2'b00, l.q});
    if (l.ovf) begin
      r = l.neg ? WMIN : WMAX;
    end else if (s > WMAX) begin
      r = WMAX;
    end else if (s < WMIN) begin
      r = WMIN;
    end else begin
      r = W'(s);
    end
    return r;
  endfunction

  assign o_move = !ov_r || out_tready;
  assign up_move = !vw_r || o_move;

  always_comb begin
    t1 = ONE_X - (W+3)'(w2_r) - (W+3)'(w0_r);
    if (degw_r) begin
      w1_nxt = '0;
    end else if (t1 > WMAX) begin
      w1_nxt = WMAX;
    end else if (t1 < WMIN) begin
      w1_nxt = WMIN;
    end else begin
      w1_nxt = W'(t1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vw_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (up_move) begin
        vw_r <= up_valid;
      end
      if (o_move) begin
        ov_r <= vw_r;
      end
    end
    if (up_move) begin
      w2_r <= up_data.deg ? '0 : sat_lane(up_data.la);
      w0_r <= up_data.deg ? '0 : sat_lane(up_data.lb);
      degw_r <= up_data.deg;
    end
    if (o_move) begin
      o1_r <= w1_nxt;
      o2_r <= w2_r;
      o0_r <= w0_r;
      odeg_r <= degw_r;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = OUT_TW'({o0_r, o2_r, o1_r});
  assign out_tuser = odeg_r;
endmodule
`default_nettype wire

// ----- hw/rtl/triangle_barycentric_weights.sv -----
// Top level of the triangle barycentric weight pipeline.
// Usage:
// The six vertex coordinates are written over the cfg channel (valid/ready,
// index 0 to 5 as v0x, v0y, v1x, v1y, v2x, v2y); cfg_ready is always high and
// unknown indexes are ignored. Write them only while the pipeline is empty.
// Each input transfer carries one point (point_x in bits 11:0, point_y in
// bits 23:12). Each result transfer carries weight_vertex1, weight_vertex2 and
// weight_vertex0 in out_tdata and the degenerate flag in out_tuser.
// Throughput is one point per clock while the receiver does not stall. A result
// passes through four front stages for differences, products and magnitudes,
// 24 divider cells that each resolve one quotient bit, one stage for sign and
// saturation and the output register for the third weight.
// Reset clears the vertices to zero and empties the pipeline. When the
// receiver stalls, results and bubbles are squeezed out stage by stage and
// in_tready falls only once every stage holds a point.
`default_nettype none
module triangle_barycentric_weights import tbw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TW-1:0]      in_tdata,    // point_x, point_y
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_TW-1:0]     out_tdata,   // weight_vertex1, weight_vertex2, weight_vertex0
  output logic                  out_tuser,   // degenerate
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data
);
  logic signed [COORD_BITS-1:0] v0x_r, v0y_r, v1x_r, v1y_r, v2x_r, v2y_r;
  logic signed [DW-1:0] dya, dxa, dyb, dxb;
  logic signed [PW-1:0] dp1_r, dp2_r;
  logic signed [EW-1:0] dsum;
  logic [EW-1:0]        dmag_r;
  logic                 dneg_r, dzero_r;

  logic                         v1_r, v2_r, v3_r, v4_r;
  logic signed [COORD_BITS-1:0] px_r, py_r;
  logic signed [PW-1:0]         ma1_r, ma2_r, mb1_r, mb2_r;
  logic signed [EW-1:0]         ea, eb;
  logic [EW-1:0]                eam_r, ebm_r;
  logic                         ean_r, ebn_r;
  stg_t                         s4_r;
  logic                         m1, m2, m3, m4;

  logic cv [0:W];
  stg_t cd [0:W];
  logic cm [0:W];

  function automatic lane_t init(logic [EW-1:0] mag, logic neg, logic [EW-1:0] d);
    logic [NB-1:0] n;
    lane_t         l;
    n = {mag, {FRACTION_BITS{1'b0}}};
    l.rem = EW'(n >> W);
    l.nlow = n[W-1:0];
    l.q = '0;
    l.neg = neg;
    l.ovf = (n >> W) >= NB'(d);
    return l;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0x_r <= '0;
      v0y_r <= '0;
      v1x_r <= '0;
      v1y_r <= '0;
      v2x_r <= '0;
      v2y_r <= '0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_V0X: v0x_r <= cfg_data;
        REG_V0Y: v0y_r <= cfg_data;
        REG_V1X: v1x_r <= cfg_data;
        REG_V1Y: v1y_r <= cfg_data;
        REG_V2X: v2x_r <= cfg_data;
        REG_V2Y: v2y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign dya = csub(v1y_r, v0y_r);
  assign dxa = csub(v0x_r, v1x_r);
  assign dyb = csub(v1y_r, v2y_r);
  assign dxb = csub(v2x_r, v1x_r);
  assign dsum = EW'(dp1_r) + EW'(dp2_r);

  always_ff @(posedge clk) begin
    dp1_r <= dya * csub(v2x_r, v1x_r);
    dp2_r <= dxa * csub(v2y_r, v1y_r);
    dmag_r <= dsum[EW-1] ? EW'(-dsum) : EW'(dsum);
    dneg_r <= dsum[EW-1];
    dzero_r <= dsum == '0;
  end

  assign m4 = !v4_r || cm[0];
  assign m3 = !v3_r || m4;
  assign m2 = !v2_r || m3;
  assign m1 = !v1_r || m2;
  assign in_tready = m1;

  assign ea = EW'(ma1_r) + EW'(ma2_r);
  assign eb = EW'(mb1_r) + EW'(mb2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (m1) v1_r <= in_tvalid;
      if (m2) v2_r <= v1_r;
      if (m3) v3_r <= v2_r;
      if (m4) v4_r <= v3_r;
    end
    if (m1) begin
      px_r <= in_tdata[COORD_BITS-1:0];
      py_r <= in_tdata[2*COORD_BITS-1:COORD_BITS];
    end
    if (m2) begin
      ma1_r <= dya * csub(px_r, v1x_r);
      ma2_r <= dxa * csub(py_r, v1y_r);
      mb1_r <= dyb * csub(px_r, v1x_r);
      mb2_r <= dxb * csub(py_r, v1y_r);
    end
    if (m3) begin
      eam_r <= ea[EW-1] ? EW'(-ea) : EW'(ea);
      ean_r <= ea[EW-1];
      ebm_r <= eb[EW-1] ? EW'(-eb) : EW'(eb);
      ebn_r <= eb[EW-1];
    end
    if (m4) begin
      s4_r.la <= init(eam_r, ean_r ^ dneg_r, dmag_r);
      s4_r.lb <= init(ebm_r, ebn_r ^ !dneg_r, dmag_r);
      s4_r.deg <= dzero_r;
    end
  end

  assign cv[0] = v4_r;
  assign cd[0] = s4_r;

  for (genvar i = 0; i < W; i++) begin : g_cell
    tbw_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cv[i]),
      .up_data  (cd[i]),
      .up_move  (cm[i]),
      .dmag     (dmag_r),
      .dn_valid (cv[i+1]),
      .dn_data  (cd[i+1]),
      .dn_move  (cm[i+1])
    );
  end

  tbw_post u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (cv[W]),
    .up_data    (cd[W]),
    .up_move    (cm[W]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );
endmodule
`default_nettype wire

// ----- hw/rtl/tbw_checker.sv -----
// Port-level checks of the triangle barycentric weight block and their binding.
`default_nettype none
module tbw_checker import tbw_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic [IN_TW-1:0]      in_tdata,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_TW-1:0]     out_tdata,
  input wire logic                  out_tuser,
  input wire logic                  cfg_valid,
  input wire logic                  cfg_ready,
  input wire logic [IDX_W-1:0]      cfg_index,
  input wire logic [COORD_BITS-1:0] cfg_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("degenerate result carries nonzero weights");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result after reset");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output stall");
endmodule

bind triangle_barycentric_weights tbw_checker u_tbw_checker (.*);
`default_nettype wire
